// ----- hdl/wram_pkg.sv -----
package wram_pkg;

  // default byte address width of the work ram
  localparam int DEF_ADDR_BITS = 15;

  // opcodes
  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_PEEK  = 2'd2;

  // access sizes, code three acts as a word
  localparam logic [1:0] SZ_BYTE = 2'd0;
  localparam logic [1:0] SZ_HALF = 2'd1;

  // controller states
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ
  } st_t;

  // request to the word memory
  typedef struct packed {
    logic       en;
    logic       we;
    logic [3:0] be;
  } mem_req_t;

endpackage

// ----- hdl/wram_mem.sv -----
module wram_mem #(
  parameter int ADDR_BITS = wram_pkg::DEF_ADDR_BITS
) (
  input  logic                   clk,
  input  wram_pkg::mem_req_t     req,
  input  logic [ADDR_BITS-3:0]   addr,
  input  logic [31:0]            wdata,
  output logic [31:0]            rdata
);
  import wram_pkg::*;

  localparam int DEPTH = 1 << (ADDR_BITS - 2);

  logic [31:0] mem [DEPTH];

  // single port word array with byte enables, registered read
  always_ff @(posedge clk) begin
    if (req.en) begin
      if (req.we) begin
        for (int i = 0; i < 4; i++) begin
          if (req.be[i]) begin
            mem[addr][8*i +: 8] <= wdata[8*i +: 8];
          end
        end
      end
      rdata <= mem[addr];
    end
  end

endmodule

// ----- hdl/wram_ctrl.sv -----
module wram_ctrl #(
  parameter int ADDR_BITS = wram_pkg::DEF_ADDR_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic [1:0]             opcode,
  input  logic [1:0]             access_size,
  input  logic [ADDR_BITS-1:0]   byte_address,
  input  logic [31:0]            write_data,
  output logic                   done,
  output logic [31:0]            read_data,
  output wram_pkg::mem_req_t     mem_req,
  output logic [ADDR_BITS-3:0]   mem_addr,
  output logic [31:0]            mem_wdata,
  input  logic [31:0]            mem_rdata
);
  import wram_pkg::*;

  // lanes touched by an access
  function automatic logic [3:0] lane_mask(input logic [1:0] size, input logic [1:0] a);
    logic [3:0] m;
    case (size)
      SZ_BYTE: m = 4'b0001 << a;
      SZ_HALF: m = a[1] ? 4'b1100 : 4'b0011;
      default: m = 4'b1111;
    endcase
    return m;
  endfunction

  // byte mask to bit mask
  function automatic logic [31:0] expand(input logic [3:0] m);
    logic [31:0] b;
    for (int i = 0; i < 4; i++) begin
      b[8*i +: 8] = {8{m[i]}};
    end
    return b;
  endfunction

  st_t                  state, state_next;
  logic [ADDR_BITS-3:0] clr_addr;
  logic [31:0]          bus_latch, bus_latch_next;
  logic                 peek_q;
  logic [3:0]           mask_q;

  logic [3:0]  lane;
  logic [31:0] wdata_rep;
  logic [31:0] merged;

  // write word with the narrow data copied into every lane
  always_comb begin
    lane = lane_mask(access_size, byte_address[1:0]);
    case (access_size)
      SZ_BYTE: wdata_rep = {4{write_data[7:0]}};
      SZ_HALF: wdata_rep = {2{write_data[15:0]}};
      default: wdata_rep = write_data;
    endcase
  end

  // read word merged into the latch lanes, raw for peek
  assign merged = peek_q ? mem_rdata
                         : ((bus_latch & ~expand(mask_q)) | (mem_rdata & expand(mask_q)));

  assign busy      = (state != ST_IDLE);
  assign read_data = merged;

  // next state, memory request and latch update
  always_comb begin
    state_next     = state;
    mem_req        = '0;
    mem_addr       = byte_address[ADDR_BITS-1:2];
    mem_wdata      = wdata_rep;
    bus_latch_next = bus_latch;
    done           = 1'b0;
    case (state)
      ST_CLEAR: begin
        mem_req.en = 1'b1;
        mem_req.we = 1'b1;
        mem_req.be = 4'b1111;
        mem_addr   = clr_addr;
        mem_wdata  = '0;
        if (clr_addr == '1) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          if (opcode == OP_WRITE) begin
            mem_req.en     = 1'b1;
            mem_req.we     = 1'b1;
            mem_req.be     = lane;
            bus_latch_next = (bus_latch & ~expand(lane)) | (wdata_rep & expand(lane));
          end else if (opcode == OP_READ || opcode == OP_PEEK) begin
            mem_req.en = 1'b1;
            state_next = ST_READ;
          end
        end
      end
      ST_READ: begin
        done       = 1'b1;
        state_next = ST_IDLE;
        if (!peek_q) begin
          bus_latch_next = merged;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // state, clear counter and latch
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      bus_latch <= '0;
    end else begin
      state     <= state_next;
      bus_latch <= bus_latch_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  // read context held for the data cycle
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      peek_q <= (opcode == OP_PEEK);
      mask_q <= lane;
    end
  end

endmodule

// ----- hdl/work_ram_access_with_bus_latch.sv -----
// work ram with byte, halfword and word access and a 32-bit bus latch
// write: no result word; busy stays low, so the next access is taken without a wait
// read or peek: result word strobed by done in the cycle after start; busy is high until then
// the single ram port serialises accesses; the receiver cannot stall, so a result is never held
// reset: latch cleared, then a clearing pass writes zero to all 2^(ADDR_BITS-2) words (8192) with busy high
module work_ram_access_with_bus_latch #(
  parameter int ADDR_BITS = wram_pkg::DEF_ADDR_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           opcode,
  input  logic [1:0]           access_size,
  input  logic [ADDR_BITS-1:0] byte_address,
  input  logic [31:0]          write_data,
  output logic                 done,
  output logic [31:0]          read_data
);
  import wram_pkg::*;

  mem_req_t             mem_req;
  logic [ADDR_BITS-3:0] mem_addr;
  logic [31:0]          mem_wdata;
  logic [31:0]          mem_rdata;

  // sequencer and bus latch
  wram_ctrl #(.ADDR_BITS(ADDR_BITS)) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .opcode       (opcode),
    .access_size  (access_size),
    .byte_address (byte_address),
    .write_data   (write_data),
    .done         (done),
    .read_data    (read_data),
    .mem_req      (mem_req),
    .mem_addr     (mem_addr),
    .mem_wdata    (mem_wdata),
    .mem_rdata    (mem_rdata)
  );

  // word store
  wram_mem #(.ADDR_BITS(ADDR_BITS)) u_mem (
    .clk   (clk),
    .req   (mem_req),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

endmodule

// ----- hdl/wram_checker.sv -----
module wram_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic [1:0] opcode,
  input logic       done
);
  import wram_pkg::*;

  // a read or peek gives its word in the next cycle
  a_read_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (opcode == OP_READ || opcode == OP_PEEK)) |=> done)
    else $error("read without result word");

  // a write gives no word
  a_write_quiet: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && opcode == OP_WRITE) |=> !done)
    else $error("write produced a result word");

  // every word follows a read or peek
  a_done_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy && (opcode == OP_READ || opcode == OP_PEEK)))
    else $error("result word without read");

  // results never come back to back
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

endmodule

bind work_ram_access_with_bus_latch wram_checker u_wram_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .opcode (opcode),
  .done   (done)
);

// ----- test/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import wram_pkg::*;

  localparam int ADDR_W = DEF_ADDR_BITS;
  localparam int RAM_BYTES = 1 << ADDR_W;
  localparam int RANDOM_ITEMS = 800;
  localparam int STALL_LIMIT = 50000;
  localparam int SETTLE_CYCLES = 4;

  // codes not named in the package
  localparam logic [1:0] SZ_WORD = 2'd2;
  localparam logic [1:0] SZ_WIDE = 2'd3;
  localparam logic [1:0] OP_NONE = 2'd3;

  typedef struct {
    logic [1:0]        op;
    logic [1:0]        size;
    logic [ADDR_W-1:0] addr;
    logic [31:0]       data;
    bit                drain;
    bit                may_idle;
  } wram_access_t;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic [1:0]        opcode;
  logic [1:0]        access_size;
  logic [ADDR_W-1:0] byte_address;
  logic [31:0]       write_data;
  logic              done;
  logic [31:0]       read_data;

  wram_access_t pending_accesses[$];
  logic [31:0]  expected_words[$];
  logic [7:0]   ram_image[RAM_BYTES];
  logic [31:0]  latch_image;
  bit           taken;
  int           stall_cycles;
  int           fail_count;

  work_ram_access_with_bus_latch dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .opcode       (opcode),
    .access_size  (access_size),
    .byte_address (byte_address),
    .write_data   (write_data),
    .done         (done),
    .read_data    (read_data)
  );

  // clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // model of the ram and bus latch, one access at a time
  task automatic model_access(input wram_access_t a, output bit has_word,
                              output logic [31:0] word);
    int wa;
    int ha;
    int ba;
    wa = int'(a.addr) & ~3;
    ha = int'(a.addr) & ~1;
    ba = int'(a.addr);
    has_word = 1'b0;
    word = '0;
    case (a.op)
      OP_PEEK: begin
        word = {ram_image[wa+3], ram_image[wa+2], ram_image[wa+1], ram_image[wa]};
        has_word = 1'b1;
      end
      OP_READ: begin
        if (a.size[1]) begin
          latch_image = {ram_image[wa+3], ram_image[wa+2], ram_image[wa+1], ram_image[wa]};
        end else if (a.size == SZ_HALF) begin
          if (ha[1]) latch_image[31:16] = {ram_image[ha+1], ram_image[ha]};
          else latch_image[15:0] = {ram_image[ha+1], ram_image[ha]};
        end else begin
          latch_image[8*ba[1:0] +: 8] = ram_image[ba];
        end
        word = latch_image;
        has_word = 1'b1;
      end
      OP_WRITE: begin
        if (a.size[1]) begin
          latch_image = a.data;
          ram_image[wa]   = a.data[7:0];
          ram_image[wa+1] = a.data[15:8];
          ram_image[wa+2] = a.data[23:16];
          ram_image[wa+3] = a.data[31:24];
        end else if (a.size == SZ_HALF) begin
          if (ha[1]) latch_image[31:16] = a.data[15:0];
          else latch_image[15:0] = a.data[15:0];
          ram_image[ha]   = a.data[7:0];
          ram_image[ha+1] = a.data[15:8];
        end else begin
          latch_image[8*ba[1:0] +: 8] = a.data[7:0];
          ram_image[ba] = a.data[7:0];
        end
      end
      default: begin
        // ignored opcode, nothing changes
      end
    endcase
  endtask

  task automatic queue_access(input logic [1:0] op, input logic [1:0] size,
                              input logic [ADDR_W-1:0] addr, input logic [31:0] data,
                              input bit drain, input bit may_idle);
    wram_access_t a;
    a.op = op;
    a.size = size;
    a.addr = addr;
    a.data = data;
    a.drain = drain;
    a.may_idle = may_idle;
    pending_accesses.push_back(a);
  endtask

  // driver: new word at the falling edge once the last one was taken
  always @(negedge clk) begin
    if (!rst && (!start || taken)) begin
      if (pending_accesses.size() == 0) begin
        start <= 1'b0;
      end else if (pending_accesses[0].drain && expected_words.size() != 0) begin
        start <= 1'b0;
      end else if (pending_accesses[0].may_idle && $urandom_range(0, 99) < 38) begin
        start <= 1'b0;
      end else begin
        wram_access_t a;
        a = pending_accesses.pop_front();
        opcode       <= a.op;
        access_size  <= a.size;
        byte_address <= a.addr;
        write_data   <= a.data;
        start        <= 1'b1;
      end
    end
  end

  // monitor: check result words and predict accepted accesses
  always @(posedge clk) begin
    wram_access_t a;
    bit has_word;
    logic [31:0] word;
    logic [31:0] want;
    if (rst) begin
      taken <= 1'b0;
      stall_cycles <= 0;
    end else begin
      if (done) begin
        if (expected_words.size() == 0) begin
          $error("unexpected result word: read_data %h", read_data);
          fail_count++;
        end else begin
          want = expected_words.pop_front();
          if (read_data !== want) begin
            $error("read_data mismatch: expected %h, actual %h", want, read_data);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        a.op = opcode;
        a.size = access_size;
        a.addr = byte_address;
        a.data = write_data;
        a.drain = 1'b0;
        a.may_idle = 1'b0;
        model_access(a, has_word, word);
        if (has_word) expected_words.push_back(word);
      end
      taken <= start && !busy;
      stall_cycles <= (done || (start && !busy)) ? 0 : stall_cycles + 1;
    end
  end

  // watchdog on cycles with no handshake
  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int n;
    int base;
    int r;
    logic [1:0] op;
    logic [1:0] size;
    logic [ADDR_W-1:0] addr;

    rst = 1'b1;
    start = 1'b0;
    opcode = OP_READ;
    access_size = SZ_BYTE;
    byte_address = '0;
    write_data = '0;
    taken = 1'b0;
    stall_cycles = 0;
    fail_count = 0;
    latch_image = '0;
    foreach (ram_image[i]) ram_image[i] = 8'h00;

    // directed: extremes, every size and opcode, lane merging, masking
    queue_access(OP_READ,  SZ_WORD, 15'h0000, 32'h0, 0, 1);
    queue_access(OP_PEEK,  SZ_BYTE, 15'h7fff, 32'h0, 0, 1);
    queue_access(OP_WRITE, SZ_WORD, 15'h7ffc, 32'hffffffff, 0, 1);
    queue_access(OP_WRITE, SZ_BYTE, 15'h7fff, 32'h0000005a, 0, 1);
    queue_access(OP_READ,  SZ_BYTE, 15'h0003, 32'h0, 0, 1);
    queue_access(OP_READ,  SZ_BYTE, 15'h7fff, 32'h0, 0, 1);
    queue_access(OP_READ,  SZ_HALF, 15'h7fff, 32'h0, 0, 1);
    queue_access(OP_WRITE, SZ_HALF, 15'h7ffd, 32'hdead1234, 0, 1);
    queue_access(OP_READ,  SZ_HALF, 15'h7ffe, 32'h0, 0, 1);
    queue_access(OP_READ,  SZ_BYTE, 15'h7ffd, 32'h0, 0, 1);
    queue_access(OP_PEEK,  SZ_HALF, 15'h7ffe, 32'h0, 0, 1);
    queue_access(OP_WRITE, SZ_WIDE, 15'h0003, 32'h89abcdef, 0, 1);
    queue_access(OP_READ,  SZ_WIDE, 15'h0001, 32'h0, 0, 1);
    queue_access(OP_NONE,  SZ_WORD, 15'h0000, 32'h12345678, 0, 1);
    queue_access(OP_NONE,  SZ_BYTE, 15'h7fff, 32'hffffffff, 0, 1);
    queue_access(OP_READ,  SZ_BYTE, 15'h0002, 32'h0, 0, 1);
    queue_access(OP_WRITE, SZ_BYTE, 15'h0001, 32'hffffff00, 0, 1);
    queue_access(OP_PEEK,  SZ_WIDE, 15'h0000, 32'h0, 0, 1);
    queue_access(OP_WRITE, SZ_WORD, 15'h0000, 32'h00000000, 0, 1);
    queue_access(OP_READ,  SZ_WORD, 15'h7ffc, 32'h0, 0, 1);
    queue_access(OP_READ,  SZ_HALF, 15'h0000, 32'h0, 0, 1);
    queue_access(OP_PEEK,  SZ_WORD, 15'h0000, 32'h0, 0, 1);

    // random: mostly clustered in a small window so reads see earlier writes
    n = 0;
    base = 0;
    while (n < RANDOM_ITEMS) begin
      if (n % 100 == 0) begin
        base = (n == 200) ? (RAM_BYTES - 64) : ($urandom_range(0, RAM_BYTES / 64 - 1) * 64);
      end
      r = $urandom_range(0, 99);
      if (r < 40) op = OP_READ;
      else if (r < 75) op = OP_WRITE;
      else if (r < 90) op = OP_PEEK;
      else op = OP_NONE;
      size = 2'($urandom_range(0, 3));
      if ($urandom_range(0, 3) == 0) addr = ADDR_W'($urandom());
      else addr = ADDR_W'(base + $urandom_range(0, 63));
      queue_access(op, size, addr, $urandom(), (n == 0) || (n == 400) ||
                   ($urandom_range(0, 99) == 0), !(n >= 500 && n < 650));
      n++;
    end

    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // wait for all words to be taken and all results back
    @(negedge clk);
    while (pending_accesses.size() != 0 || (start && !taken) || expected_words.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    if (expected_words.size() != 0) begin
      $error("%0d result words never arrived", expected_words.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
